FILE: hdl/day_number_to_tabular_islamic_date_macros.svh
// Assertion macros for the checker file dnti_chk.
`ifndef DAY_NUMBER_TO_TABULAR_ISLAMIC_DATE_MACROS_SVH
`define DAY_NUMBER_TO_TABULAR_ISLAMIC_DATE_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define DNTI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define DNTI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/dnti_pkg.sv
package dnti_pkg;

  localparam int DAY_NUMBER_BITS = 24;
  localparam int YEAR_BITS = 16;
  localparam int MONTH_BITS = 4;
  localparam int DAY_BITS = 5;

  localparam int DIC_BITS = 14;
  localparam int DIY_BITS = 9;
  localparam int REM_BITS = DIC_BITS + 1;
  localparam int YI_BITS = 5;
  localparam int MI_BITS = 4;

  // 10631 lies between 2^13 and 2^14
  localparam int QUO_BITS = DAY_NUMBER_BITS - 13;
  localparam int RECIP_BITS = DAY_NUMBER_BITS - 13;

  localparam int CYCLE_YEARS = 30;
  localparam int MONTHS = 12;

  localparam logic [DAY_NUMBER_BITS-1:0] EPOCH_DAY = DAY_NUMBER_BITS'(1948440);
  localparam logic [DIC_BITS-1:0] CYCLE_DAYS = DIC_BITS'(10631);
  localparam logic [RECIP_BITS-1:0] CYCLE_RECIP =
    RECIP_BITS'((64'd1 << DAY_NUMBER_BITS) / 64'd10631);

  localparam logic [DIC_BITS-1:0] YEAR_END [CYCLE_YEARS] = '{
    14'd354, 14'd709, 14'd1063, 14'd1417, 14'd1772, 14'd2126, 14'd2481, 14'd2835,
    14'd3189, 14'd3544, 14'd3898, 14'd4252, 14'd4607, 14'd4961, 14'd5315, 14'd5670,
    14'd6024, 14'd6379, 14'd6733, 14'd7087, 14'd7442, 14'd7796, 14'd8150, 14'd8505,
    14'd8859, 14'd9214, 14'd9568, 14'd9922, 14'd10277, 14'd10631
  };

  localparam logic [DIC_BITS-1:0] YEAR_START [CYCLE_YEARS] = '{
    14'd0, 14'd354, 14'd709, 14'd1063, 14'd1417, 14'd1772, 14'd2126, 14'd2481,
    14'd2835, 14'd3189, 14'd3544, 14'd3898, 14'd4252, 14'd4607, 14'd4961, 14'd5315,
    14'd5670, 14'd6024, 14'd6379, 14'd6733, 14'd7087, 14'd7442, 14'd7796, 14'd8150,
    14'd8505, 14'd8859, 14'd9214, 14'd9568, 14'd9922, 14'd10277
  };

  localparam logic [DIY_BITS-1:0] MONTH_END [MONTHS] = '{
    9'd30, 9'd59, 9'd89, 9'd118, 9'd148, 9'd177,
    9'd207, 9'd236, 9'd266, 9'd295, 9'd325, 9'd355
  };

  localparam logic [DIY_BITS-1:0] MONTH_START [MONTHS] = '{
    9'd0, 9'd30, 9'd59, 9'd89, 9'd118, 9'd148,
    9'd177, 9'd207, 9'd236, 9'd266, 9'd295, 9'd325
  };

  // Pre-epoch flag, whole cycles and day within the cycle, handed from divider to date lookup
  typedef struct packed {
    logic                pre;
    logic [QUO_BITS-1:0] cycle;
    logic [DIC_BITS-1:0] dic;
  } dnti_cyc_t;

endpackage

FILE: hdl/dnti_div.sv
module dnti_div
  import dnti_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [DAY_NUMBER_BITS-1:0] day_number,
  output logic                       cyc_valid,
  input  logic                       cyc_ready,
  output dnti_cyc_t                  cyc
);

  localparam int PROD_BITS = DAY_NUMBER_BITS + RECIP_BITS;
  localparam int QPROD_BITS = QUO_BITS + DIC_BITS;

  // stage 1: input register
  logic                       v1;
  logic [DAY_NUMBER_BITS-1:0] dn1;
  // stage 2: offset from epoch
  logic                       v2;
  logic                       pre2;
  logic [DAY_NUMBER_BITS-1:0] off2;
  // stage 3: estimated quotient
  logic                       v3;
  logic                       pre3;
  logic [QUO_BITS-1:0]        qe3;
  logic [REM_BITS-1:0]        offlo3;
  // stage 4: quotient times cycle length, low bits
  logic                       v4;
  logic                       pre4;
  logic [QUO_BITS-1:0]        qe4;
  logic [REM_BITS-1:0]        offlo4;
  logic [REM_BITS-1:0]        mlo4;
  // stage 5: corrected quotient and remainder
  logic                       v5;
  dnti_cyc_t                  cyc5;

  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [PROD_BITS-1:0]  prod;
  logic [QPROD_BITS-1:0] qprod;
  logic [REM_BITS-1:0]   rem;
  logic [REM_BITS-1:0]   rem_sub;
  logic                  fix;
  dnti_cyc_t             cyc_next;

  assign rdy5 = !v5 || cyc_ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  // reciprocal estimate is at most one below the true quotient
  assign prod = PROD_BITS'(off2) * PROD_BITS'(CYCLE_RECIP);
  assign qprod = QPROD_BITS'(qe3) * QPROD_BITS'(CYCLE_DAYS);

  // true remainder stays below twice the cycle length, so low bits suffice
  assign rem = offlo4 - mlo4;
  assign rem_sub = rem - REM_BITS'(CYCLE_DAYS);
  assign fix = rem >= REM_BITS'(CYCLE_DAYS);

  always_comb begin
    cyc_next.pre = pre4;
    cyc_next.cycle = fix ? qe4 + QUO_BITS'(1) : qe4;
    cyc_next.dic = fix ? rem_sub[DIC_BITS-1:0] : rem[DIC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) dn1 <= day_number;
    if (rdy2 && v1) begin
      pre2 <= dn1 < EPOCH_DAY;
      off2 <= dn1 - EPOCH_DAY;
    end
    if (rdy3 && v2) begin
      pre3 <= pre2;
      qe3 <= prod[PROD_BITS-1 -: QUO_BITS];
      offlo3 <= off2[REM_BITS-1:0];
    end
    if (rdy4 && v3) begin
      pre4 <= pre3;
      qe4 <= qe3;
      offlo4 <= offlo3;
      mlo4 <= qprod[REM_BITS-1:0];
    end
    if (rdy5 && v4) cyc5 <= cyc_next;
  end

  assign cyc_valid = v5;
  assign cyc = cyc5;

endmodule

FILE: hdl/dnti_date.sv
module dnti_date
  import dnti_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cyc_valid,
  output logic                  cyc_ready,
  input  dnti_cyc_t             cyc,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [YEAR_BITS-1:0]  year,
  output logic [MONTH_BITS-1:0] month,
  output logic [DAY_BITS-1:0]   day
);

  // stage 6: year within cycle
  logic                  v6;
  logic                  pre6;
  logic [QUO_BITS-1:0]   cycle6;
  logic [YI_BITS-1:0]    yi6;
  logic [DIY_BITS-1:0]   diy6;
  // stage 7: result register
  logic                  v7;
  logic [YEAR_BITS-1:0]  year7;
  logic [MONTH_BITS-1:0] month7;
  logic [DAY_BITS-1:0]   day7;

  logic rdy6, rdy7;

  logic [YI_BITS-1:0]    yi_next;
  logic [DIY_BITS-1:0]   diy_next;
  logic [MI_BITS-1:0]    mi;
  logic [YEAR_BITS-1:0]  year_next;
  logic [MONTH_BITS-1:0] month_next;
  logic [DAY_BITS-1:0]   day_next;

  assign rdy7 = !v7 || out_ready;
  assign rdy6 = !v6 || rdy7;
  assign cyc_ready = rdy6;

  // first year end above the day in the cycle
  always_comb begin
    yi_next = YI_BITS'(CYCLE_YEARS - 1);
    for (int i = CYCLE_YEARS - 1; i >= 0; i--) begin
      if (cyc.dic < YEAR_END[i]) yi_next = YI_BITS'(i);
    end
    diy_next = DIY_BITS'(cyc.dic - YEAR_START[yi_next]);
  end

  // first month end above the day in the year
  always_comb begin
    mi = MI_BITS'(MONTHS - 1);
    for (int i = MONTHS - 1; i >= 0; i--) begin
      if (diy6 < MONTH_END[i]) mi = MI_BITS'(i);
    end
    if (pre6) begin
      year_next = '0;
      month_next = '0;
      day_next = '0;
    end else begin
      year_next = YEAR_BITS'(cycle6) * YEAR_BITS'(CYCLE_YEARS)
                + YEAR_BITS'(yi6) + YEAR_BITS'(1);
      month_next = MONTH_BITS'(mi) + MONTH_BITS'(1);
      day_next = DAY_BITS'(diy6 - MONTH_START[mi]) + DAY_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy6) v6 <= cyc_valid;
      if (rdy7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6 && cyc_valid) begin
      pre6 <= cyc.pre;
      cycle6 <= cyc.cycle;
      yi6 <= yi_next;
      diy6 <= diy_next;
    end
    if (rdy7 && v6) begin
      year7 <= year_next;
      month7 <= month_next;
      day7 <= day_next;
    end
  end

  assign out_valid = v7;
  assign year = year7;
  assign month = month7;
  assign day = day7;

endmodule

FILE: hdl/day_number_to_tabular_islamic_date.sv
// Pipeline: seven register stages (input, offset, reciprocal multiply, remainder multiply,
// correction, year lookup, and month lookup into the result).
// Throughput: one word per cycle while out_ready is high; each stage holds its word only while the next is full.
// Reset: synchronous, clears every stage valid flag; the datapath is not reset.
module day_number_to_tabular_islamic_date
  import dnti_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [DAY_NUMBER_BITS-1:0] day_number,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [YEAR_BITS-1:0]       year,
  output logic [MONTH_BITS-1:0]      month,
  output logic [DAY_BITS-1:0]        day
);

  logic      cyc_valid;
  logic      cyc_ready;
  dnti_cyc_t cyc;

  dnti_div u_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .day_number (day_number),
    .cyc_valid  (cyc_valid),
    .cyc_ready  (cyc_ready),
    .cyc        (cyc)
  );

  dnti_date u_date (
    .clk       (clk),
    .rst       (rst),
    .cyc_valid (cyc_valid),
    .cyc_ready (cyc_ready),
    .cyc       (cyc),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .year      (year),
    .month     (month),
    .day       (day)
  );

endmodule

FILE: hdl/dnti_chk.sv
`include "day_number_to_tabular_islamic_date_macros.svh"

module dnti_chk
  import dnti_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [DAY_NUMBER_BITS-1:0] day_number,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [YEAR_BITS-1:0]       year,
  input logic [MONTH_BITS-1:0]      month,
  input logic [DAY_BITS-1:0]        day
);

  // hold a stalled result
  `DNTI_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(year) && $stable(month) && $stable(day), "stalled result changed")

  `DNTI_ASSERT(a_zero_date, out_valid |-> ((month == '0) == (day == '0)), "month and day disagree on pre-epoch")

  `DNTI_ASSERT(a_date_range, out_valid |-> (month <= MONTH_BITS'(12)) && (day <= DAY_BITS'(30)), "month or day out of range")

  // only month 12 of the even months may reach day 30
  `DNTI_ASSERT(a_short_month, out_valid && (month != '0) && !month[0] && (month != MONTH_BITS'(12)) |-> (day <= DAY_BITS'(29)), "even month longer than 29 days")

  `DNTI_ASSERT_ALWAYS(a_reset_empty, rst |=> in_ready && !out_valid, "pipeline not empty after reset")

endmodule

bind day_number_to_tabular_islamic_date dnti_chk u_chk (.*);
